// ===== rtl/core/dehqp_pkg.sv =====
// Package with shared types, codes and constants of the digit-extraction hash core.
package dehqp_pkg;

   // Default number of table entries.
   localparam int TABLE_DEPTH_DEFAULT = 128;

   // Input modes.
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_READ   = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_ZERO_KEY  = 2'd2;
   localparam logic [1:0] STATUS_BAD_SLOT  = 2'd3;

   // Register indexes, decoded from paddr[2].
   localparam logic REG_TABLE_SIZE = 1'b0;
   localparam logic REG_DIGIT_MASK = 1'b1;

   // Register reset values.
   localparam logic [7:0] TABLE_SIZE_RESET = 8'd128;
   localparam logic [9:0] DIGIT_MASK_RESET = 10'd1023;

   // Reciprocal of ten for a 32-bit dividend: q = (x * DIV10_MAGIC) >> DIV10_SHIFT.
   localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
   localparam int          DIV10_SHIFT = 35;

   // Width of the extracted decimal value (up to ten digits).
   localparam int VALUE_WIDTH = 34;

   // Input beat.
   typedef struct packed {
      logic        mode;
      logic [30:0] key;
      logic [6:0]  slot;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  home_index;
      logic [6:0]  placed_index;
      logic [6:0]  probe_count;
      logic [31:0] total_collisions;
      logic [30:0] entry_value;
   } rsp_type;

endpackage

// ===== rtl/core/dehqp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dehqp_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/digit_extraction_hash_quadratic_probe_core.sv =====
// Top level of the digit-extraction hash core with quadratic probing.
//
// Usage: an input beat (req_item) is taken when start is high and busy is low.
// Mode insert hashes a nonzero key and stores it in the first free slot on the
// quadratic probe path; mode read returns the contents of one slot. Each beat
// gives exactly one result beat on rsp_item, marked by rsp_valid for a single
// cycle; the receiver cannot hold it off, so it must take it in that cycle.
// An insert extracts ten digits on one shared divide-by-ten multiplier, then
// reduces the value by a bit-serial modulo by the table size and reads each
// probed slot (RAM read with registered data); a read fetches one slot the same
// way. A rejected key or bad slot is answered from idle and leaves busy low;
// otherwise busy stays high from the accepting edge until the result beat is
// shown. Reset (synchronous, active high) restores the control registers and the
// APB registers and starts a clearing pass that writes zero to all TABLE_DEPTH
// entries, one per cycle, with busy high throughout. Register writes on the APB
// port are taken at any time but are meant for idle periods only.
module digit_extraction_hash_quadratic_probe_core
   import dehqp_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   // Result channel
   output logic        rsp_valid,
   output rsp_type     rsp_item,
   // Register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IDXW = $clog2(TABLE_DEPTH);
   localparam int SZW  = $clog2(TABLE_DEPTH + 1);
   localparam int CW   = (SZW > 8) ? SZW : 8;
   localparam int VW   = VALUE_WIDTH;
   localparam int MCW  = $clog2(VW);

   // State codes.
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DIGIT  = 3'd2;
   localparam logic [2:0] S_MOD    = 3'd3;
   localparam logic [2:0] S_PADDR  = 3'd4;
   localparam logic [2:0] S_PCHECK = 3'd5;
   localparam logic [2:0] S_RADDR  = 3'd6;
   localparam logic [2:0] S_RDATA  = 3'd7;

   logic [2:0]      state_ff, state_in;
   logic [7:0]      table_size_ff;
   logic [9:0]      digit_mask_ff;
   logic [IDXW:0]   clr_ff, clr_in;
   logic [30:0]     key_ff, key_in;
   logic [30:0]     rest_ff, rest_in;
   logic [27:0]     quot_ff, quot_in;
   logic            phase_ff, phase_in;
   logic [3:0]      pos_ff, pos_in;
   logic [VW-1:0]   value_ff, value_in;
   logic [VW-1:0]   weight_ff, weight_in;
   logic [MCW-1:0]  mod_cnt_ff, mod_cnt_in;
   logic [CW-1:0]   rem_ff, rem_in;
   logic [CW-1:0]   home_ff, home_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic [CW-1:0]   inc_ff, inc_in;
   logic [CW-1:0]   step_ff, step_in;
   logic [6:0]      probes_ff, probes_in;
   logic [31:0]     coll_ff, coll_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic [CW-1:0]   size_ext;
   logic [CW-1:0]   eff_size;
   logic            accept;
   logic            cfg_write;
   logic [62:0]     div_prod;
   logic [30:0]     digit_diff;
   logic [3:0]      digit;
   logic [CW:0]     mod_trial;
   logic [CW:0]     idx_sum;
   logic [CW:0]     inc_sum;
   logic [CW-1:0]   idx_step;
   logic [CW-1:0]   inc_step;
   logic [6:0]      probes_sat;
   logic [31:0]     coll_sat;

   logic            ram_we;
   logic [IDXW-1:0] ram_waddr;
   logic [30:0]     ram_wdata;
   logic [30:0]     ram_rdata;

   dehqp_ram #(
      .WIDTH (31),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (idx_ff[IDXW-1:0]),
      .rdata (ram_rdata)
   );

   // Register port: always ready, written on the access cycle.
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;
   assign prdata    = (paddr[2] == REG_DIGIT_MASK) ? {22'd0, digit_mask_ff}
                                                   : {24'd0, table_size_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RESET;
         digit_mask_ff <= DIGIT_MASK_RESET;
      end else if (cfg_write) begin
         if (paddr[2] == REG_TABLE_SIZE) begin
            table_size_ff <= pwdata[7:0];
         end else begin
            digit_mask_ff <= pwdata[9:0];
         end
      end
   end

   // Effective table size: zero counts as one, capped at the table depth.
   assign size_ext = CW'(table_size_ff);
   assign eff_size = (size_ext == '0) ? CW'(1)
                   : (size_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : size_ext;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start & ~busy;

   // Divide by ten through the reciprocal, then the remainder digit.
   assign div_prod   = 63'(rest_ff) * 63'(DIV10_MAGIC);
   assign digit_diff = rest_ff - ((31'(quot_ff) << 3) + (31'(quot_ff) << 1));
   assign digit      = digit_diff[3:0];

   // Restoring modulo step on the next bit of the extracted value.
   assign mod_trial = {rem_ff, value_ff[VW-1]};

   // Next probe position and next increment (raised by two), both kept below the size.
   assign idx_sum  = {1'b0, idx_ff} + {1'b0, inc_ff};
   assign inc_sum  = {1'b0, inc_ff} + (CW+1)'(2);
   assign idx_step = (idx_sum >= {1'b0, eff_size}) ? CW'(idx_sum - {1'b0, eff_size})
                                                   : idx_sum[CW-1:0];
   assign inc_step = (inc_sum >= {1'b0, eff_size}) ? CW'(inc_sum - {1'b0, eff_size})
                                                   : inc_sum[CW-1:0];

   assign probes_sat = (probes_ff == 7'd127) ? probes_ff : probes_ff + 7'd1;
   assign coll_sat   = (coll_ff == 32'hFFFF_FFFF) ? coll_ff : coll_ff + 32'd1;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      key_in       = key_ff;
      rest_in      = rest_ff;
      quot_in      = quot_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      value_in     = value_ff;
      weight_in    = weight_ff;
      mod_cnt_in   = mod_cnt_ff;
      rem_in       = rem_ff;
      home_in      = home_ff;
      idx_in       = idx_ff;
      inc_in       = inc_ff;
      step_in      = step_ff;
      probes_in    = probes_ff;
      coll_in      = coll_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff[IDXW-1:0];
      ram_wdata    = key_ff;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff[IDXW-1:0];
            ram_wdata = '0;
            clr_in    = clr_ff + (IDXW+1)'(1);
            if (clr_ff == (IDXW+1)'(TABLE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               rsp_in                  = '0;
               rsp_in.total_collisions = coll_ff;
               key_in                  = req_item.key;
               if (req_item.mode == MODE_READ) begin
                  rsp_in.placed_index = req_item.slot;
                  if (CW'(req_item.slot) >= eff_size) begin
                     rsp_in.status = STATUS_BAD_SLOT;
                     rsp_valid_in  = 1'b1;
                  end else begin
                     idx_in   = CW'(req_item.slot);
                     state_in = S_RADDR;
                  end
               end else if (req_item.key == '0) begin
                  rsp_in.status = STATUS_ZERO_KEY;
                  rsp_valid_in  = 1'b1;
               end else begin
                  rest_in   = req_item.key;
                  value_in  = '0;
                  weight_in = VW'(1);
                  pos_in    = '0;
                  phase_in  = 1'b0;
                  state_in  = S_DIGIT;
               end
            end
         end

         S_DIGIT: begin
            if (!phase_ff) begin
               quot_in  = div_prod[62:DIV10_SHIFT];
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               rest_in  = 31'(quot_ff);
               if (digit_mask_ff[pos_ff]) begin
                  value_in  = value_ff + VW'(weight_ff * VW'(digit));
                  weight_in = (weight_ff << 3) + (weight_ff << 1);
               end
               pos_in = pos_ff + 4'd1;
               if (pos_ff == 4'd9) begin
                  rem_in     = '0;
                  mod_cnt_in = '0;
                  state_in   = S_MOD;
               end
            end
         end

         S_MOD: begin
            rem_in     = (mod_trial >= {1'b0, eff_size}) ? CW'(mod_trial - {1'b0, eff_size})
                                                        : mod_trial[CW-1:0];
            value_in   = value_ff << 1;
            mod_cnt_in = mod_cnt_ff + MCW'(1);
            if (mod_cnt_ff == MCW'(VW - 1)) begin
               home_in   = rem_in;
               idx_in    = rem_in;
               inc_in    = (eff_size == CW'(1)) ? '0 : CW'(1);
               step_in   = CW'(1);
               probes_in = '0;
               state_in  = S_PADDR;
            end
         end

         S_PADDR: begin
            state_in = S_PCHECK;
         end

         S_PCHECK: begin
            rsp_in.home_index = home_ff[6:0];
            if (ram_rdata == '0) begin
               ram_we                  = 1'b1;
               rsp_in.status           = STATUS_OK;
               rsp_in.placed_index     = idx_ff[6:0];
               rsp_in.probe_count      = probes_ff;
               rsp_in.total_collisions = coll_ff;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end else begin
               probes_in = probes_sat;
               coll_in   = coll_sat;
               if (step_ff >= eff_size) begin
                  rsp_in.status           = STATUS_FULL;
                  rsp_in.placed_index     = '0;
                  rsp_in.probe_count      = probes_sat;
                  rsp_in.total_collisions = coll_sat;
                  rsp_valid_in            = 1'b1;
                  state_in                = S_IDLE;
               end else begin
                  idx_in   = idx_step;
                  inc_in   = inc_step;
                  step_in  = step_ff + CW'(1);
                  state_in = S_PADDR;
               end
            end
         end

         S_RADDR: begin
            state_in = S_RDATA;
         end

         S_RDATA: begin
            rsp_in.entry_value = ram_rdata;
            rsp_valid_in       = 1'b1;
            state_in           = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         coll_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         coll_ff      <= coll_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      rest_ff    <= rest_in;
      quot_ff    <= quot_in;
      phase_ff   <= phase_in;
      pos_ff     <= pos_in;
      value_ff   <= value_in;
      weight_ff  <= weight_in;
      mod_cnt_ff <= mod_cnt_in;
      rem_ff     <= rem_in;
      home_ff    <= home_in;
      idx_ff     <= idx_in;
      inc_ff     <= inc_in;
      step_ff    <= step_in;
      probes_ff  <= probes_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The probe position always stays inside the table in use.
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PCHECK) |-> (idx_ff < eff_size))
      else $error("probe index beyond table size");

   // The modulo remainder stays below the divisor.
   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOD) |-> (rem_ff < eff_size))
      else $error("modulo remainder out of range");

   // A result beat is only shown after an accepted beat or during work.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) != S_IDLE || $past(start)))
      else $error("result beat without a request");

   // The collision total never goes down outside reset.
   a_coll_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (coll_ff >= $past(coll_ff)))
      else $error("collision total decreased");

   // An accepted beat always makes the core busy or answers at once.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid_ff))
      else $error("accepted beat dropped");

endmodule
